// ===== hdl/tcw_pkg.sv =====
// Shared types, constants and the control program of the text console writer.
// Holds the screen geometry, transaction structs and the microcode ROM.
// No dependencies.
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    // Internal widths derived from the geometry
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int CELL_W = $clog2(CELLS);
    localparam int OFS_W  = $clog2((ROWS + 1) * COLUMNS);
    localparam int SUM_W  = COL_W + 2;

    // Transaction field widths
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int OCOL_W = 7;
    localparam int OROW_W = 5;
    localparam int HW_W   = 11;
    localparam int DATA_W = 16;
    localparam int TAB_W  = 5;
    localparam int ATTR_W = 8;

    // Configuration port
    localparam int ADDR_W    = 3;
    localparam int PDATA_W   = 32;
    localparam logic REG_TAB  = 1'b0;
    localparam logic REG_ATTR = 1'b1;
    localparam logic [TAB_W-1:0]  TAB_RESET  = 5'd8;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } in_item_t;

    typedef struct packed {
        logic [OCOL_W-1:0] cursor_col;
        logic [OROW_W-1:0] cursor_row;
        logic [HW_W-1:0]   hw_cursor_offset;
        logic [DATA_W-1:0] cell_data;
    } out_item_t;

    // Program steps
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_PUT,
        ST_SCR_COPY,
        ST_SCR_DRAIN,
        ST_SCR_BLANK,
        ST_SCR_END,
        ST_CHAR,
        ST_EMIT,
        ST_CLR_FILL,
        ST_CLR_END,
        ST_RD_ISSUE,
        ST_RD_CAP
    } step_t;

    typedef enum logic [1:0] {WR_NONE, WR_FILL, WR_CHAR} wr_t;
    typedef enum logic [1:0] {RD_NONE, RD_COPY, RD_INDEX} rd_t;
    typedef enum logic [1:0] {PTR_HOLD, PTR_CLEAR, PTR_INC, PTR_LAST_ROW} ptr_op_t;
    typedef enum logic {LIM_CELLS, LIM_COPY} lim_t;
    typedef enum logic [1:0] {CUR_HOLD, CUR_HOME, CUR_SCROLLED, CUR_CHAR} cur_op_t;
    typedef enum logic [1:0] {DAT_HOLD, DAT_ZERO, DAT_CAPTURE} dat_op_t;
    typedef enum logic [1:0] {DONE_HOLD, DONE_SET, DONE_CLEAR} done_op_t;

    typedef enum logic [2:0] {
        CND_ALWAYS,
        CND_PTR_LAST,
        CND_IN_VALID,
        CND_NOT_FULL,
        CND_DONE,
        CND_TAB_SCROLL,
        CND_OUT_FREE,
        CND_DISPATCH
    } cond_t;

    // Control word driving the datapath
    typedef struct packed {
        logic     take_in;
        wr_t      wr;
        rd_t      rd;
        ptr_op_t  ptr_op;
        lim_t     lim;
        logic     fill_reset;
        cur_op_t  cur;
        dat_op_t  dat;
        done_op_t done;
        logic     emit;
    } ctl_t;

    // Full microcode word: control plus branch
    typedef struct packed {
        ctl_t  ctl;
        cond_t cond;
        step_t tgt_true;
        step_t tgt_false;
    } uword_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            ptr_last;
        logic            row_full;
        logic            char_done;
        logic            tab_scroll;
    } dp_stat_t;

    // Microcode ROM
    function automatic uword_t ucode(input step_t step);
        uword_t w;
        w = '0;
        w.tgt_true  = ST_IDLE;
        w.tgt_false = ST_IDLE;
        unique case (step)
            ST_INIT:
            begin
                w.ctl.wr = WR_FILL;
                w.ctl.fill_reset = 1'b1;
                w.ctl.ptr_op = PTR_INC;
                w.ctl.lim = LIM_CELLS;
                w.cond = CND_PTR_LAST;
                w.tgt_true = ST_IDLE;
                w.tgt_false = ST_INIT;
            end
            ST_IDLE:
            begin
                w.ctl.take_in = 1'b1;
                w.cond = CND_IN_VALID;
                w.tgt_true = ST_DISPATCH;
                w.tgt_false = ST_IDLE;
            end
            ST_DISPATCH:
            begin
                w.ctl.ptr_op = PTR_CLEAR;
                w.ctl.dat = DAT_ZERO;
                w.ctl.done = DONE_CLEAR;
                w.cond = CND_DISPATCH;
            end
            ST_PUT:
            begin
                w.cond = CND_NOT_FULL;
                w.tgt_true = ST_CHAR;
                w.tgt_false = ST_SCR_COPY;
            end
            ST_SCR_COPY:
            begin
                w.ctl.rd = RD_COPY;
                w.ctl.ptr_op = PTR_INC;
                w.ctl.lim = LIM_COPY;
                w.cond = CND_PTR_LAST;
                w.tgt_true = ST_SCR_DRAIN;
                w.tgt_false = ST_SCR_COPY;
            end
            ST_SCR_DRAIN:
            begin
                w.ctl.ptr_op = PTR_LAST_ROW;
                w.cond = CND_ALWAYS;
                w.tgt_true = ST_SCR_BLANK;
            end
            ST_SCR_BLANK:
            begin
                w.ctl.wr = WR_FILL;
                w.ctl.ptr_op = PTR_INC;
                w.ctl.lim = LIM_CELLS;
                w.cond = CND_PTR_LAST;
                w.tgt_true = ST_SCR_END;
                w.tgt_false = ST_SCR_BLANK;
            end
            ST_SCR_END:
            begin
                w.ctl.cur = CUR_SCROLLED;
                w.cond = CND_DONE;
                w.tgt_true = ST_EMIT;
                w.tgt_false = ST_CHAR;
            end
            ST_CHAR:
            begin
                w.ctl.cur = CUR_CHAR;
                w.ctl.wr = WR_CHAR;
                w.ctl.done = DONE_SET;
                w.ctl.ptr_op = PTR_CLEAR;
                w.cond = CND_TAB_SCROLL;
                w.tgt_true = ST_SCR_COPY;
                w.tgt_false = ST_EMIT;
            end
            ST_EMIT:
            begin
                w.ctl.emit = 1'b1;
                w.cond = CND_OUT_FREE;
                w.tgt_true = ST_IDLE;
                w.tgt_false = ST_EMIT;
            end
            ST_CLR_FILL:
            begin
                w.ctl.wr = WR_FILL;
                w.ctl.ptr_op = PTR_INC;
                w.ctl.lim = LIM_CELLS;
                w.cond = CND_PTR_LAST;
                w.tgt_true = ST_CLR_END;
                w.tgt_false = ST_CLR_FILL;
            end
            ST_CLR_END:
            begin
                w.ctl.cur = CUR_HOME;
                w.cond = CND_ALWAYS;
                w.tgt_true = ST_EMIT;
            end
            ST_RD_ISSUE:
            begin
                w.ctl.rd = RD_INDEX;
                w.cond = CND_ALWAYS;
                w.tgt_true = ST_RD_CAP;
            end
            ST_RD_CAP:
            begin
                w.ctl.dat = DAT_CAPTURE;
                w.cond = CND_ALWAYS;
                w.tgt_true = ST_EMIT;
            end
            default:
            begin
                w.cond = CND_ALWAYS;
                w.tgt_true = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    // Dispatch table: first step of each operation
    function automatic step_t dispatch(input logic [OP_W-1:0] op);
        step_t s;
        unique case (op)
            OP_PUT:   s = ST_PUT;
            OP_CLEAR: s = ST_CLR_FILL;
            OP_READ:  s = ST_RD_ISSUE;
            default:  s = ST_EMIT;
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/tcw_seq.sv =====
// Microcode sequencer: step counter, program ROM lookup and branch logic.
// Depends on tcw_pkg.
module tcw_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  tcw_pkg::dp_stat_t stat,
    input  logic             in_valid,
    input  logic             out_free,
    output tcw_pkg::ctl_t    ctl
);
    import tcw_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    uword_t word;
    logic   cond_hit;

    // Fetch the control word of the current step
    always_comb
    begin
        word = ucode(step_reg);
        ctl  = word.ctl;
    end

    // Evaluate branch condition and pick the next step
    always_comb
    begin
        unique case (word.cond)
            CND_ALWAYS:     cond_hit = 1'b1;
            CND_PTR_LAST:   cond_hit = stat.ptr_last;
            CND_IN_VALID:   cond_hit = in_valid;
            CND_NOT_FULL:   cond_hit = !stat.row_full;
            CND_DONE:       cond_hit = stat.char_done;
            CND_TAB_SCROLL: cond_hit = stat.tab_scroll;
            CND_OUT_FREE:   cond_hit = out_free;
            CND_DISPATCH:   cond_hit = 1'b1;
            default:        cond_hit = 1'b1;
        endcase
        if (word.cond == CND_DISPATCH)
        begin
            step_next = dispatch(stat.op);
        end
        else if (cond_hit)
        begin
            step_next = word.tgt_true;
        end
        else
        begin
            step_next = word.tgt_false;
        end
    end

    // Step counter, starts with the store clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_INIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== hdl/tcw_dp.sv =====
// Datapath: cell store, sweep pointer, cursor registers and read capture.
// Depends on tcw_pkg and tcw_ram; driven by control words from tcw_seq.
module tcw_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tcw_pkg::ctl_t                ctl,
    input  logic                         in_valid,
    input  tcw_pkg::in_item_t            in_data,
    input  logic [tcw_pkg::TAB_W-1:0]    tab_width,
    input  logic [tcw_pkg::ATTR_W-1:0]   text_attribute,
    output tcw_pkg::dp_stat_t            stat,
    output tcw_pkg::out_item_t           result
);
    import tcw_pkg::*;

    in_item_t            item_reg;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic [HW_W-1:0]     hw_reg;
    logic [HW_W-1:0]     hw_next;
    logic [CELL_W-1:0]   ptr_reg;
    logic [CELL_W-1:0]   ptr_next;
    logic [DATA_W-1:0]   data_reg;
    logic [DATA_W-1:0]   data_next;
    logic                done_reg;
    logic                done_next;
    logic                cpy_pend_reg;
    logic [CELL_W-1:0]   cpy_addr_reg;

    logic [SUM_W-1:0]    tab_sum;
    logic [SUM_W-1:0]    col_inc;
    logic [ROW_W-1:0]    row_inc;
    logic [COL_W-1:0]    ch_col;
    logic [ROW_W-1:0]    ch_row;
    logic                ch_place;
    logic                ch_print;
    logic [OFS_W-1:0]    cur_ofs;
    logic [CELL_W-1:0]   cur_loc;
    logic                idx_ok;

    logic                ram_we;
    logic [CELL_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [CELL_W-1:0]   ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    function automatic logic [HW_W-1:0] place_ofs(input logic [COL_W-1:0] c,
                                                   input logic [ROW_W-1:0] r);
        logic [OFS_W-1:0] o;
        o = OFS_W'(r) * OFS_W'(COLUMNS) + OFS_W'(c);
        return HW_W'(o);
    endfunction

    tcw_ram #(
        .WIDTH(DATA_W),
        .DEPTH(CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Cursor movement for one put character
    always_comb
    begin
        tab_sum  = SUM_W'(col_reg) + SUM_W'(tab_width);
        col_inc  = SUM_W'(col_reg) + SUM_W'(1);
        row_inc  = row_reg + ROW_W'(1);
        ch_col   = col_reg;
        ch_row   = row_reg;
        ch_place = 1'b0;
        ch_print = 1'b0;
        unique case (item_reg.char_code)
            CH_NL:
            begin
                ch_col   = '0;
                ch_row   = row_inc;
                ch_place = (row_inc != ROW_W'(ROWS));
            end
            CH_TAB:
            begin
                if (tab_sum >= SUM_W'(COLUMNS))
                begin
                    ch_col = '0;
                    ch_row = row_inc;
                end
                else
                begin
                    ch_col = COL_W'(tab_sum);
                end
                ch_place = (ch_row != ROW_W'(ROWS));
            end
            CH_CR:
            begin
                ch_col   = '0;
                ch_row   = row_inc;
                ch_place = 1'b1;
            end
            CH_BS:
            begin
                if (col_reg != '0)
                begin
                    ch_col   = col_reg - COL_W'(1);
                    ch_place = 1'b1;
                end
            end
            default:
            begin
                ch_print = 1'b1;
                if (col_inc >= SUM_W'(COLUMNS))
                begin
                    ch_col = '0;
                    ch_row = row_inc;
                end
                else
                begin
                    ch_col = COL_W'(col_inc);
                end
                ch_place = (ch_row != ROW_W'(ROWS));
            end
        endcase
    end

    // Cell address under the cursor and read range check
    always_comb
    begin
        cur_ofs = OFS_W'(row_reg) * OFS_W'(COLUMNS) + OFS_W'(col_reg);
        cur_loc = CELL_W'(cur_ofs);
        idx_ok  = (32'(item_reg.cell_index) < CELLS);
    end

    // Store write and read ports; a pending copy write takes precedence
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = {text_attribute, BLANK_CHAR};
        if (cpy_pend_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = cpy_addr_reg;
            ram_wdata = ram_rdata;
        end
        else
        begin
            unique case (ctl.wr)
                WR_NONE:
                begin
                    ram_we = 1'b0;
                end
                WR_FILL:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ptr_reg;
                    ram_wdata = ctl.fill_reset ? {RESET_ATTR, BLANK_CHAR}
                                               : {text_attribute, BLANK_CHAR};
                end
                WR_CHAR:
                begin
                    ram_we    = ch_print;
                    ram_waddr = cur_loc;
                    ram_wdata = {text_attribute, item_reg.char_code};
                end
                default:
                begin
                    ram_we = 1'b0;
                end
            endcase
        end
        unique case (ctl.rd)
            RD_COPY:  ram_raddr = ptr_reg + CELL_W'(COLUMNS);
            RD_INDEX: ram_raddr = CELL_W'(item_reg.cell_index);
            default:  ram_raddr = ptr_reg;
        endcase
    end

    // Sweep pointer
    always_comb
    begin
        unique case (ctl.ptr_op)
            PTR_CLEAR:    ptr_next = '0;
            PTR_INC:      ptr_next = ptr_reg + CELL_W'(1);
            PTR_LAST_ROW: ptr_next = CELL_W'((ROWS - 1) * COLUMNS);
            default:      ptr_next = ptr_reg;
        endcase
    end

    // Cursor update
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        hw_next  = hw_reg;
        unique case (ctl.cur)
            CUR_HOME:
            begin
                col_next = '0;
                row_next = '0;
                hw_next  = '0;
            end
            CUR_SCROLLED:
            begin
                col_next = '0;
                row_next = ROW_W'(ROWS - 1);
                hw_next  = place_ofs('0, ROW_W'(ROWS - 1));
            end
            CUR_CHAR:
            begin
                col_next = ch_col;
                row_next = ch_row;
                if (ch_place)
                begin
                    hw_next = place_ofs(ch_col, ch_row);
                end
            end
            default:
            begin
                col_next = col_reg;
            end
        endcase
    end

    // Read data and character-done flag
    always_comb
    begin
        unique case (ctl.dat)
            DAT_ZERO:    data_next = '0;
            DAT_CAPTURE: data_next = idx_ok ? ram_rdata : '0;
            default:     data_next = data_reg;
        endcase
        unique case (ctl.done)
            DONE_SET:   done_next = 1'b1;
            DONE_CLEAR: done_next = 1'b0;
            default:    done_next = done_reg;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            hw_reg       <= '0;
            ptr_reg      <= '0;
            done_reg     <= 1'b0;
            cpy_pend_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            hw_reg       <= hw_next;
            ptr_reg      <= ptr_next;
            done_reg     <= done_next;
            cpy_pend_reg <= (ctl.rd == RD_COPY);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.take_in && in_valid)
        begin
            item_reg <= in_data;
        end
        data_reg     <= data_next;
        cpy_addr_reg <= ptr_reg;
    end

    // Status and result
    always_comb
    begin
        stat.op         = item_reg.op;
        stat.ptr_last   = (ctl.lim == LIM_COPY)
                          ? (ptr_reg == CELL_W'((ROWS - 1) * COLUMNS - 1))
                          : (ptr_reg == CELL_W'(CELLS - 1));
        stat.row_full   = (row_reg == ROW_W'(ROWS));
        stat.char_done  = done_reg;
        stat.tab_scroll = (item_reg.char_code == CH_TAB) && (ch_row == ROW_W'(ROWS));

        result.cursor_col       = OCOL_W'(col_reg);
        result.cursor_row       = OROW_W'(row_reg);
        result.hw_cursor_offset = hw_reg;
        result.cell_data        = data_reg;
    end

endmodule

// ===== hdl/text_console_writer.sv =====
// Text console writer, top level: config registers, sequencer, datapath, result register.
// Each transaction yields one result; an unused op goes straight to the result register;
// a put may scroll the screen, and a tab after a pending scroll may scroll twice; clear
// blanks every cell and homes the cursor. A stalled result register adds its wait.
// One transaction at a time through the store port: a new one is taken only after the last result is loaded.
// Reset: an initial pass writes every cell of the store, one per cycle, with in_stall
// high; configuration writes are taken meanwhile.
// Depends on tcw_pkg, tcw_seq, tcw_dp and tcw_ram.
module text_console_writer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  tcw_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output tcw_pkg::out_item_t            out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcw_pkg::ADDR_W-1:0]    paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]   pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import tcw_pkg::*;

    logic [TAB_W-1:0]  tab_reg;
    logic [ATTR_W-1:0] attr_reg;
    ctl_t              ctl;
    dp_stat_t          stat;
    out_item_t         result;
    logic              out_free;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    tcw_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .in_valid (in_valid),
        .out_free (out_free),
        .ctl      (ctl)
    );

    tcw_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .in_valid       (in_valid),
        .in_data        (in_data),
        .tab_width      (tab_reg),
        .text_attribute (attr_reg),
        .stat           (stat),
        .result         (result)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_reg  <= TAB_RESET;
            attr_reg <= ATTR_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_TAB:  tab_reg  <= pwdata[TAB_W-1:0];
                REG_ATTR: attr_reg <= pwdata[ATTR_W-1:0];
                default:  tab_reg  <= tab_reg;
            endcase
        end
    end

    // Configuration reads
    always_comb
    begin
        pready = 1'b1;
        unique case (paddr[2])
            REG_TAB:  prdata = PDATA_W'(tab_reg);
            REG_ATTR: prdata = PDATA_W'(attr_reg);
            default:  prdata = '0;
        endcase
    end

    // Input handshake
    assign in_stall = !ctl.take_in;

    // Result register: load on emit, drop when taken
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit && out_free)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
